/* design/csl_pkg.sv */
// Shared types, constants and keyword tables for the source lexer.
package csl_pkg;

    localparam int IDENT_MAX  = 16;
    localparam int COUNT_BITS = 32;
    localparam int NKW        = 15;

    localparam logic [2:0] KIND_NUMBER  = 3'd0;
    localparam logic [2:0] KIND_KEYWORD = 3'd1;
    localparam logic [2:0] KIND_IDENT   = 3'd2;
    localparam logic [2:0] KIND_SPECIAL = 3'd3;
    localparam logic [2:0] KIND_TOTALS  = 3'd4;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] number_value;
        logic [3:0]  keyword_id;
        logic [7:0]  ident_length;
        logic [7:0]  special_char;
        logic [31:0] line_count;
        logic [31:0] space_count;
        logic [31:0] tab_count;
        logic [31:0] token_count;
        logic        last;
    } out_item_t;

    // Keyword text, position 0 in the low byte.
    typedef logic [63:0] kw_text_t;

    function automatic kw_text_t kw_text(input int k);
        case (k)
            0:  kw_text = {"\0\0\0\0\0", "rof"};
            1:  kw_text = {"\0\0\0", "elihw"};
            2:  kw_text = {"\0\0\0\0\0\0", "od"};
            3:  kw_text = {"\0\0\0\0\0", "tni"};
            4:  kw_text = {"\0\0\0", "taolf"};
            5:  kw_text = {"\0\0\0\0", "rahc"};
            6:  kw_text = {"\0\0", "elbuod"};
            7:  kw_text = {"\0\0", "citats"};
            8:  kw_text = {"\0\0", "hctiws"};
            9:  kw_text = {"\0\0\0\0", "esac"};
            10: kw_text = {"\0\0\0\0", "gnol"};
            11: kw_text = {"\0", "edulcni"};
            12: kw_text = {"\0\0\0\0", "niam"};
            13: kw_text = {"\0\0\0\0", "tuoc"};
            14: kw_text = {"\0\0\0\0\0", "nic"};
            default: kw_text = '0;
        endcase
    endfunction

    function automatic logic [7:0] kw_len(input int k);
        case (k)
            0, 3, 14:             kw_len = 8'd3;
            1, 4:                 kw_len = 8'd5;
            2:                    kw_len = 8'd2;
            5, 9, 10, 12, 13:     kw_len = 8'd4;
            6, 7, 8:              kw_len = 8'd6;
            11:                   kw_len = 8'd7;
            default:              kw_len = 8'd0;
        endcase
    endfunction

    // Bump a saturating counter.
    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        bump = (&v) ? v : v + 1'b1;
    endfunction

    // Clamp a counter to the 32-bit report field.
    function automatic logic [31:0] sat32(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        sat32 = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    // Queue entry: up to two results of one character.
    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } pair_t;

endpackage

/* design/csl_front.sv */
// Front end: accepts characters, runs the lexer state and forms result pairs.
module csl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  csl_pkg::in_item_t in_item,
    input  logic              in_fire,
    output csl_pkg::pair_t    pair,
    output logic              pair_valid
);
    import csl_pkg::*;

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_NUM   = 7'b0000010,
        M_IDENT = 7'b0000100,
        M_SLASH = 7'b0001000,
        M_LINE  = 7'b0010000,
        M_BLOCK = 7'b0100000,
        M_STAR  = 7'b1000000
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [31:0]           acc_reg, acc_next;
    logic [NKW-1:0]        cand_reg, cand_next;
    logic [7:0]            len_reg, len_next;
    logic [COUNT_BITS-1:0] lines_reg, lines_next, spaces_reg, spaces_next;
    logic [COUNT_BITS-1:0] tabs_reg, tabs_next, tokens_reg, tokens_next;

    logic [7:0]  c;
    logic        c_digit, c_alpha;
    logic [35:0] sum10;
    out_item_t   res [2];
    logic [1:0]  n;

    function automatic logic [NKW-1:0] narrow(input logic [NKW-1:0] m,
                                              input logic [7:0] ch,
                                              input logic [7:0] pos);
        logic [NKW-1:0] r;
        kw_text_t t;
        r = m;
        for (int k = 0; k < NKW; k++)
        begin
            t = kw_text(k);
            if (pos >= 8'(IDENT_MAX) || pos >= kw_len(k) || t[pos[2:0]*8 +: 8] != ch)
                r[k] = 1'b0;
        end
        return r;
    endfunction

    function automatic out_item_t blank();
        out_item_t r;
        r = '0;
        return r;
    endfunction

    assign c       = in_item.ch;
    assign c_digit = (c >= "0") && (c <= "9");
    assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign sum10   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 36'(c - "0");

    // Next-state logic for one character or end of input.
    always_comb
    begin
        logic [3:0] hit;
        logic       found;
        logic       fresh;
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        cand_next   = cand_reg;
        len_next    = len_reg;
        lines_next  = lines_reg;
        spaces_next = spaces_reg;
        tabs_next   = tabs_reg;
        tokens_next = tokens_reg;
        res[0] = blank();
        res[1] = blank();
        n      = 2'd0;
        fresh  = 1'b0;
        hit    = '0;
        found  = 1'b0;
        for (int k = NKW - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && kw_len(k) == len_reg)
            begin
                hit   = 4'(k);
                found = 1'b1;
            end
        end

        if (in_item.action == ACT_END || !(
                (mode_reg == M_NUM && c_digit) ||
                (mode_reg == M_IDENT && (c_alpha || c_digit || c == "_" || c == "$")) ||
                (mode_reg == M_SLASH && (c == "/" || c == "*")) ||
                mode_reg == M_LINE || mode_reg == M_BLOCK || mode_reg == M_STAR))
        begin
            // Flush pending token.
            case (mode_reg)
                M_NUM:
                begin
                    res[0].kind = KIND_NUMBER;
                    res[0].number_value = acc_reg;
                    n = 2'd1;
                end
                M_IDENT:
                begin
                    res[0].kind = found ? KIND_KEYWORD : KIND_IDENT;
                    res[0].keyword_id = found ? hit : 4'd0;
                    res[0].ident_length = len_reg;
                    n = 2'd1;
                end
                M_SLASH:
                begin
                    res[0].kind = KIND_SPECIAL;
                    res[0].special_char = "/";
                    n = 2'd1;
                end
                default: n = 2'd0;
            endcase
            if (n == 2'd1)
                tokens_next = bump(tokens_reg);
            mode_next = M_IDLE;
            fresh = (in_item.action == ACT_CHAR);
        end
        else
        begin
            case (mode_reg)
                M_NUM:
                    acc_next = (sum10 > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum10[31:0];
                M_IDENT:
                begin
                    cand_next = narrow(cand_reg, c, len_reg);
                    if (len_reg != 8'hFF)
                        len_next = len_reg + 8'd1;
                end
                M_SLASH:
                    mode_next = (c == "/") ? M_LINE : M_BLOCK;
                M_LINE:
                    if (c == 8'h0A)
                    begin
                        mode_next  = M_IDLE;
                        lines_next = bump(lines_reg);
                    end
                default:
                begin
                    if (c == 8'h0A)
                        lines_next = bump(lines_reg);
                    if (mode_reg == M_STAR && c == "/")
                        mode_next = M_IDLE;
                    else
                        mode_next = (c == "*") ? M_STAR : M_BLOCK;
                end
            endcase
        end

        // Character handled as fresh from idle.
        if (fresh)
        begin
            if (c_digit)
            begin
                acc_next  = 32'(c - "0");
                mode_next = M_NUM;
            end
            else if (c_alpha)
            begin
                cand_next = narrow({NKW{1'b1}}, c, 8'd0);
                len_next  = 8'd1;
                mode_next = M_IDENT;
            end
            else if (c == " ")
                spaces_next = bump(spaces_reg);
            else if (c == 8'h09)
                tabs_next = bump(tabs_reg);
            else if (c == 8'h0A)
                lines_next = bump(lines_reg);
            else if (c == "/")
                mode_next = M_SLASH;
            else
            begin
                res[n[0]] = blank();
                res[n[0]].kind = KIND_SPECIAL;
                res[n[0]].special_char = c;
                n = n + 2'd1;
                tokens_next = bump(tokens_next);
            end
        end

        // Totals on end of input, then back to reset state.
        if (in_item.action == ACT_END)
        begin
            res[n[0]] = blank();
            res[n[0]].kind        = KIND_TOTALS;
            res[n[0]].line_count  = sat32(lines_next);
            res[n[0]].space_count = sat32(spaces_next);
            res[n[0]].tab_count   = sat32(tabs_next);
            res[n[0]].token_count = sat32(tokens_next);
            n = n + 2'd1;
            mode_next   = M_IDLE;
            acc_next    = '0;
            cand_next   = {NKW{1'b1}};
            len_next    = '0;
            lines_next  = '0;
            spaces_next = '0;
            tabs_next   = '0;
            tokens_next = '0;
        end

        if (n == 2'd2)
            res[1].last = 1'b1;
        else if (n == 2'd1)
            res[0].last = 1'b1;
    end

    assign pair.two    = (n == 2'd2);
    assign pair.first  = res[0];
    assign pair.second = res[1];
    assign pair_valid  = in_fire && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            acc_reg    <= '0;
            cand_reg   <= {NKW{1'b1}};
            len_reg    <= '0;
            lines_reg  <= '0;
            spaces_reg <= '0;
            tabs_reg   <= '0;
            tokens_reg <= '0;
        end
        else if (in_fire)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            cand_reg   <= cand_next;
            len_reg    <= len_next;
            lines_reg  <= lines_next;
            spaces_reg <= spaces_next;
            tabs_reg   <= tabs_next;
            tokens_reg <= tokens_next;
        end
    end

endmodule

/* design/csl_back.sv */
// Back end: a two-entry queue of result pairs, drained one result per transfer.
module csl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  csl_pkg::pair_t     pair,
    input  logic               pair_valid,
    output logic               can_take,
    output csl_pkg::out_item_t out_item,
    output logic               out_valid,
    input  logic               out_ready
);
    import csl_pkg::*;

    pair_t      q_reg [2];
    logic       wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       half_reg, half_next;
    logic       pop;

    assign can_take  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = half_reg ? q_reg[rd_reg].second : q_reg[rd_reg].first;
    assign pop       = out_valid && out_ready && (half_reg || !q_reg[rd_reg].two);

    // Pointer and count update.
    always_comb
    begin
        wr_next   = wr_reg ^ pair_valid;
        rd_next   = rd_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, pair_valid} - {1'b0, pop};
        half_next = half_reg;
        if (out_valid && out_ready)
            half_next = !pop;
    end

    always_ff @(posedge clk)
    begin
        if (pair_valid)
            q_reg[wr_reg] <= pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            cnt_reg  <= 2'd0;
            half_reg <= 1'b0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            cnt_reg  <= cnt_next;
            half_reg <= half_next;
        end
    end

endmodule

/* design/c_source_lexer.sv */
// Top level of the character-serial source lexer.
// One character is taken per cycle while the result queue has room; each
// character gives zero, one or two results (a token ending plus a special
// character), delivered one per output transfer from a two-entry queue of
// result pairs. End of input gives any pending token, then the totals, and
// returns the lexer to its reset state. Sustained rate is one character per
// cycle unless the output side stalls or two-result characters arrive faster
// than results drain.
module c_source_lexer (
    input  logic               clk,
    input  logic               rst_n,
    input  csl_pkg::in_item_t  in_item,
    input  logic               in_valid,
    output logic               in_ready,
    output csl_pkg::out_item_t out_item,
    output logic               out_valid,
    input  logic               out_ready
);
    import csl_pkg::*;

    pair_t pair;
    logic  pair_valid;
    logic  can_take;

    assign in_ready = can_take;

    csl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .in_fire    (in_valid && in_ready),
        .pair       (pair),
        .pair_valid (pair_valid)
    );

    csl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair),
        .pair_valid (pair_valid),
        .can_take   (can_take),
        .out_item   (out_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

/* design/csl_checker.sv */
// Port-level checker for the source lexer, bound to the top level.
module csl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input csl_pkg::out_item_t out_item,
    input logic               out_valid,
    input logic               out_ready
);
    import csl_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input offer dropped while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.kind <= KIND_TOTALS)
        else $error("bad kind");

    a_totals_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_TOTALS |-> out_item.last)
        else $error("totals not last");

    a_kw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.keyword_id < 4'(NKW))
        else $error("bad keyword id");

endmodule

bind c_source_lexer csl_checker u_csl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
